@@ rtl/core/zip_local_header_walker_defines.svh @@
// assertion macros for the zip local header walker checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ZIP_LOCAL_HEADER_WALKER_DEFINES_SVH
`define ZIP_LOCAL_HEADER_WALKER_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define ZLHW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("zlhw check failed");

// consequent that must hold in the cycle after the antecedent
`define ZLHW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("zlhw check failed");

`endif

@@ rtl/core/zlhw_pkg.sv @@
// types and constants shared by the zip local header walker
// no dependencies
package zlhw_pkg;

    // walk phases; the codes double as byte class values
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_EXTRA  = 3'd2,
        PH_DATA   = 3'd3,
        PH_DESC   = 3'd4,
        PH_STOP   = 3'd5
    } phase_t;

    localparam logic [2:0]  CLS_HEADER = 3'd0;
    localparam logic [2:0]  CLS_NAME   = 3'd1;
    localparam logic [2:0]  CLS_EXTRA  = 3'd2;
    localparam logic [2:0]  CLS_DATA   = 3'd3;
    localparam logic [2:0]  CLS_DESC   = 3'd4;
    localparam logic [2:0]  CLS_STOP   = 3'd5;

    localparam logic [31:0] LOCAL_SIG  = 32'h04034b50;
    localparam logic [31:0] DESC_SIG   = 32'h08074b50;
    localparam int unsigned DESC_FLAG_BIT = 3;
    localparam logic [4:0]  DESC_LONG  = 5'd16;
    localparam logic [4:0]  DESC_SHORT = 5'd12;
    localparam logic [4:0]  HDR_LAST   = 5'd29;
    localparam logic [15:0] METHOD_STORE   = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE = 16'd8;

    // one result of the walker
    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  byte_out;
        logic        header_done;
        logic        name_last;
        logic        data_last;
        logic [15:0] comp_method;
        logic        method_supported;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        logic [15:0] entry_number;
    } result_t;

endpackage

@@ rtl/core/zlhw_core.sv @@
// walk state and per-byte classification of the zip local header walker
// depends on zlhw_pkg
module zlhw_core
    import zlhw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] byte_in,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] section_count_reg, section_count_next;
    logic [31:0] sig_word_reg, sig_word_next;
    logic [15:0] gp_flags_reg, gp_flags_next;
    logic [15:0] method_reg, method_next;
    logic [31:0] packed_len_reg, packed_len_next;
    logic [31:0] unpacked_len_reg, unpacked_len_next;
    logic [15:0] name_len_reg, name_len_next;
    logic [15:0] extra_len_reg, extra_len_next;
    logic [31:0] desc_word_reg, desc_word_next;
    logic [4:0]  desc_total_reg, desc_total_next;
    logic [15:0] entry_counter_reg, entry_counter_next;

    logic [4:0]  hdr_idx;
    logic [31:0] idx_inc;
    logic        exit_en;
    phase_t      exit_from;
    logic [2:0]  cls;
    logic        hdone, nlast, dlast;

    // walk state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            section_count_reg <= '0;
            sig_word_reg      <= '0;
            gp_flags_reg      <= '0;
            method_reg        <= '0;
            packed_len_reg    <= '0;
            unpacked_len_reg  <= '0;
            name_len_reg      <= '0;
            extra_len_reg     <= '0;
            desc_word_reg     <= '0;
            desc_total_reg    <= '0;
            entry_counter_reg <= '0;
        end else if (byte_en) begin
            phase_reg         <= phase_next;
            section_count_reg <= section_count_next;
            sig_word_reg      <= sig_word_next;
            gp_flags_reg      <= gp_flags_next;
            method_reg        <= method_next;
            packed_len_reg    <= packed_len_next;
            unpacked_len_reg  <= unpacked_len_next;
            name_len_reg      <= name_len_next;
            extra_len_reg     <= extra_len_next;
            desc_word_reg     <= desc_word_next;
            desc_total_reg    <= desc_total_next;
            entry_counter_reg <= entry_counter_next;
        end
    end

    // header byte index, clamped to the last header byte
    assign hdr_idx = (section_count_reg >= 32'd30) ? HDR_LAST : section_count_reg[4:0];
    assign idx_inc = section_count_reg + 32'd1;

    // next state for one byte
    always_comb begin
        phase_next         = phase_reg;
        section_count_next = section_count_reg;
        sig_word_next      = sig_word_reg;
        gp_flags_next      = gp_flags_reg;
        method_next        = method_reg;
        packed_len_next    = packed_len_reg;
        unpacked_len_next  = unpacked_len_reg;
        name_len_next      = name_len_reg;
        extra_len_next     = extra_len_reg;
        desc_word_next     = desc_word_reg;
        desc_total_next    = desc_total_reg;
        entry_counter_next = entry_counter_reg;
        exit_en            = 1'b0;
        exit_from          = PH_HEADER;
        cls                = CLS_STOP;
        hdone              = 1'b0;
        nlast              = 1'b0;
        dlast              = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                cls = CLS_HEADER;
                // first header byte clears the previous entry's fields
                if (hdr_idx == 5'd0) begin
                    sig_word_next     = '0;
                    gp_flags_next     = '0;
                    method_next       = '0;
                    packed_len_next   = '0;
                    unpacked_len_next = '0;
                    name_len_next     = '0;
                    extra_len_next    = '0;
                end
                // little-endian field capture
                if (hdr_idx < 5'd4) begin
                    sig_word_next[{hdr_idx[1:0], 3'b000} +: 8] = byte_in;
                end else if (hdr_idx < 5'd6) begin
                    // version needed, not kept
                end else if (hdr_idx < 5'd8) begin
                    gp_flags_next[{hdr_idx[0], 3'b000} +: 8] = byte_in;
                end else if (hdr_idx < 5'd10) begin
                    method_next[{hdr_idx[0], 3'b000} +: 8] = byte_in;
                end else if (hdr_idx < 5'd18) begin
                    // time, date and crc, not kept
                end else if (hdr_idx < 5'd22) begin
                    packed_len_next[{hdr_idx[1:0] + 2'd2, 3'b000} +: 8] = byte_in;
                end else if (hdr_idx < 5'd26) begin
                    unpacked_len_next[{hdr_idx[1:0] + 2'd2, 3'b000} +: 8] = byte_in;
                end else if (hdr_idx < 5'd28) begin
                    name_len_next[{hdr_idx[0], 3'b000} +: 8] = byte_in;
                end else begin
                    extra_len_next[{hdr_idx[0], 3'b000} +: 8] = byte_in;
                end
                // signature check, then header end
                if (hdr_idx == 5'd3 && sig_word_next != LOCAL_SIG) begin
                    phase_next = PH_STOP;
                end else if (hdr_idx == HDR_LAST) begin
                    hdone     = 1'b1;
                    exit_en   = 1'b1;
                    exit_from = PH_HEADER;
                end else begin
                    section_count_next = {27'd0, hdr_idx + 5'd1};
                end
            end
            PH_NAME: begin
                cls = CLS_NAME;
                if (idx_inc >= {16'd0, name_len_reg}) begin
                    nlast     = 1'b1;
                    exit_en   = 1'b1;
                    exit_from = PH_NAME;
                end else begin
                    section_count_next = idx_inc;
                end
            end
            PH_EXTRA: begin
                cls = CLS_EXTRA;
                if (idx_inc >= {16'd0, extra_len_reg}) begin
                    exit_en   = 1'b1;
                    exit_from = PH_EXTRA;
                end else begin
                    section_count_next = idx_inc;
                end
            end
            PH_DATA: begin
                cls = CLS_DATA;
                if (section_count_reg >= packed_len_reg - 32'd1) begin
                    dlast     = 1'b1;
                    exit_en   = 1'b1;
                    exit_from = PH_DATA;
                end else begin
                    section_count_next = idx_inc;
                end
            end
            PH_DESC: begin
                cls = CLS_DESC;
                // lead-in word decides the descriptor length
                if (section_count_reg < 32'd4) begin
                    desc_word_next[{section_count_reg[1:0], 3'b000} +: 8] = byte_in;
                end
                if (section_count_reg == 32'd3) begin
                    desc_total_next = (desc_word_next == DESC_SIG) ? DESC_LONG : DESC_SHORT;
                end
                if (desc_total_next != 5'd0 && idx_inc >= {27'd0, desc_total_next}) begin
                    exit_en   = 1'b1;
                    exit_from = PH_DESC;
                end else begin
                    section_count_next = idx_inc;
                end
            end
            default: begin
                cls        = CLS_STOP;
                phase_next = PH_STOP;
            end
        endcase

        // move on to the next non-empty section or the next entry
        if (exit_en) begin
            section_count_next = '0;
            if (exit_from < PH_NAME && name_len_next != 16'd0) begin
                phase_next = PH_NAME;
            end else if (exit_from < PH_EXTRA && extra_len_next != 16'd0) begin
                phase_next = PH_EXTRA;
            end else if (exit_from < PH_DATA && packed_len_next != 32'd0) begin
                phase_next = PH_DATA;
            end else if (exit_from < PH_DESC && gp_flags_next[DESC_FLAG_BIT]) begin
                phase_next      = PH_DESC;
                desc_word_next  = '0;
                desc_total_next = '0;
            end else begin
                phase_next         = PH_HEADER;
                entry_counter_next = entry_counter_reg + 16'd1;
            end
        end
    end

    // result shows the state after this byte
    always_comb begin
        res.byte_class       = cls;
        res.byte_out         = byte_in;
        res.header_done      = hdone;
        res.name_last        = nlast;
        res.data_last        = dlast;
        res.comp_method      = method_next;
        res.method_supported = (method_next == METHOD_STORE) ||
                               (method_next == METHOD_DEFLATE);
        res.packed_size      = packed_len_next;
        res.unpacked_size    = unpacked_len_next;
        res.entry_number     = entry_counter_next;
    end

endmodule

@@ rtl/core/zip_local_header_walker.sv @@
// Walks the local file entries of a ZIP archive fed one byte per transfer and
// returns one result per byte: its class, the byte itself, end-of-header,
// end-of-name and end-of-data marks, and the current entry's method, sizes and
// index. The block takes one byte every cycle while s_ready is high, and each result
// is registered before it reaches the m_ side. All per-byte work is one pass of
// logic from the walk state to the result register, and a two-entry output
// buffer (result register plus skid register) keeps s_ready high while a
// single result waits, so a stall on m_ready reaches s_ready only after two
// results are held. A signature mismatch on a header stops the walk until reset.
// Depends on zlhw_pkg and zlhw_core.
module zip_local_header_walker
    import zlhw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_class,
    output logic [7:0]  m_byte_out,
    output logic        m_header_done,
    output logic        m_name_last,
    output logic        m_data_last,
    output logic [15:0] m_comp_method,
    output logic        m_method_supported,
    output logic [31:0] m_packed_size,
    output logic [31:0] m_unpacked_size,
    output logic [15:0] m_entry_number
);

    result_t step_res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    s_xfer;
    logic    out_free;

    assign s_ready  = !skid_valid_reg;
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // walk state and classification
    zlhw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (s_xfer),
        .byte_in (s_byte_in),
        .res     (step_res)
    );

    // output buffer occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || s_xfer;
            skid_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_xfer) begin
                out_reg <= step_res;
            end
        end else if (s_xfer) begin
            skid_reg <= step_res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_byte_class       = out_reg.byte_class;
    assign m_byte_out         = out_reg.byte_out;
    assign m_header_done      = out_reg.header_done;
    assign m_name_last        = out_reg.name_last;
    assign m_data_last        = out_reg.data_last;
    assign m_comp_method      = out_reg.comp_method;
    assign m_method_supported = out_reg.method_supported;
    assign m_packed_size      = out_reg.packed_size;
    assign m_unpacked_size    = out_reg.unpacked_size;
    assign m_entry_number     = out_reg.entry_number;

endmodule

@@ rtl/core/zlhw_checker.sv @@
// port-level checks for the zip local header walker, bound to the top level
// depends on zlhw_pkg and zip_local_header_walker_defines.svh
`include "zip_local_header_walker_defines.svh"

module zlhw_checker
    import zlhw_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_byte_class,
    input logic [7:0]  m_byte_out,
    input logic        m_header_done,
    input logic        m_name_last,
    input logic        m_data_last,
    input logic [15:0] m_comp_method,
    input logic        m_method_supported
);

    logic        stalled;
    logic [10:0] out_key;
    logic        marks_ok;
    logic        flag_ok;

    // terms used by the checks below
    assign stalled  = m_valid && !m_ready;
    assign out_key  = {m_byte_class, m_byte_out};
    assign marks_ok = (!m_header_done || m_byte_class == CLS_HEADER) &&
                      (!m_name_last || m_byte_class == CLS_NAME) &&
                      (!m_data_last || m_byte_class == CLS_DATA);
    assign flag_ok  = m_method_supported ==
                      ((m_comp_method == METHOD_STORE) || (m_comp_method == METHOD_DEFLATE));

    // a stalled result holds its byte and class
    `ZLHW_ASSERT_NEXT(a_out_hold, aclk, aresetn, stalled, m_valid && $stable(out_key))

    // marks only appear on bytes of the matching section
    `ZLHW_ASSERT(a_marks_class, aclk, aresetn, !m_valid || marks_ok)

    // support flag follows the method field
    `ZLHW_ASSERT(a_method_flag, aclk, aresetn, !m_valid || flag_ok)

    // class codes stay within the defined set
    `ZLHW_ASSERT(a_class_range, aclk, aresetn, !m_valid || m_byte_class <= CLS_STOP)

endmodule

bind zip_local_header_walker zlhw_checker u_zlhw_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_byte_class       (m_byte_class),
    .m_byte_out         (m_byte_out),
    .m_header_done      (m_header_done),
    .m_name_last        (m_name_last),
    .m_data_last        (m_data_last),
    .m_comp_method      (m_comp_method),
    .m_method_supported (m_method_supported)
);

@@ dv/zip_local_header_walker_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for zip_local_header_walker: byte streams of local entries
// are checked per result against a behavioral walker; depends on zlhw_pkg and the rtl
module zip_local_header_walker_tb;
    import zlhw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_byte_class;
    logic [7:0]  m_byte_out;
    logic        m_header_done;
    logic        m_name_last;
    logic        m_data_last;
    logic [15:0] m_comp_method;
    logic        m_method_supported;
    logic [31:0] m_packed_size;
    logic [31:0] m_unpacked_size;
    logic [15:0] m_entry_number;

    zip_local_header_walker u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_byte_in          (s_byte_in),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_byte_class       (m_byte_class),
        .m_byte_out         (m_byte_out),
        .m_header_done      (m_header_done),
        .m_name_last        (m_name_last),
        .m_data_last        (m_data_last),
        .m_comp_method      (m_comp_method),
        .m_method_supported (m_method_supported),
        .m_packed_size      (m_packed_size),
        .m_unpacked_size    (m_unpacked_size),
        .m_entry_number     (m_entry_number)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // walker state mirrored by the predictor
    phase_t      walk_phase;
    logic [31:0] sec_idx;
    logic [31:0] sig_w;
    logic [15:0] flag_w;
    logic [15:0] method_w;
    logic [31:0] plen_w;
    logic [31:0] ulen_w;
    logic [15:0] nlen_w;
    logic [15:0] xlen_w;
    logic [31:0] lead_w;
    logic [4:0]  desc_len;
    logic [15:0] entry_cnt;

    result_t     expected_results[$];
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          quiet_cycles   = 0;
    int          stall_left     = 0;
    bit          idle_on        = 1'b1;

    function automatic void clear_walker();
        walk_phase = PH_HEADER;
        sec_idx    = '0;
        sig_w      = '0;
        flag_w     = '0;
        method_w   = '0;
        plen_w     = '0;
        ulen_w     = '0;
        nlen_w     = '0;
        xlen_w     = '0;
        lead_w     = '0;
        desc_len   = '0;
        entry_cnt  = '0;
    endfunction

    // jump to the next non-empty section, or close the entry
    function automatic void leave_section(input phase_t done);
        sec_idx = '0;
        if (done < PH_NAME && nlen_w != 0) begin
            walk_phase = PH_NAME;
        end else if (done < PH_EXTRA && xlen_w != 0) begin
            walk_phase = PH_EXTRA;
        end else if (done < PH_DATA && plen_w != 0) begin
            walk_phase = PH_DATA;
        end else if (done < PH_DESC && flag_w[DESC_FLAG_BIT]) begin
            walk_phase = PH_DESC;
            lead_w     = '0;
            desc_len   = '0;
        end else begin
            walk_phase = PH_HEADER;
            entry_cnt  = entry_cnt + 16'd1;
        end
    endfunction

    // take one byte into the walker and return its expected result
    function automatic result_t walk_byte(input logic [7:0] b);
        result_t     r;
        logic [31:0] idx;
        logic [31:0] off;
        r   = '0;
        idx = sec_idx;
        case (walk_phase)
            PH_HEADER: begin
                r.byte_class = CLS_HEADER;
                if (idx > 32'(HDR_LAST)) idx = 32'(HDR_LAST);
                // a new header drops the previous entry's fields
                if (idx == 0) begin
                    sig_w    = '0;
                    flag_w   = '0;
                    method_w = '0;
                    plen_w   = '0;
                    ulen_w   = '0;
                    nlen_w   = '0;
                    xlen_w   = '0;
                end
                if (idx < 4) begin
                    sig_w[8*idx[1:0] +: 8] = b;
                end else if (idx == 6 || idx == 7) begin
                    flag_w[8*idx[0] +: 8] = b;
                end else if (idx == 8 || idx == 9) begin
                    method_w[8*idx[0] +: 8] = b;
                end else if (idx >= 18 && idx < 22) begin
                    off = idx - 18;
                    plen_w[8*off[1:0] +: 8] = b;
                end else if (idx >= 22 && idx < 26) begin
                    off = idx - 22;
                    ulen_w[8*off[1:0] +: 8] = b;
                end else if (idx == 26 || idx == 27) begin
                    nlen_w[8*idx[0] +: 8] = b;
                end else if (idx >= 28) begin
                    xlen_w[8*idx[0] +: 8] = b;
                end
                if (idx == 3 && sig_w != LOCAL_SIG) begin
                    walk_phase = PH_STOP;
                end else if (idx == 32'(HDR_LAST)) begin
                    r.header_done = 1'b1;
                    leave_section(PH_HEADER);
                end else begin
                    sec_idx = idx + 1;
                end
            end
            PH_NAME: begin
                r.byte_class = CLS_NAME;
                if (idx + 1 >= 32'(nlen_w)) begin
                    r.name_last = 1'b1;
                    leave_section(PH_NAME);
                end else begin
                    sec_idx = idx + 1;
                end
            end
            PH_EXTRA: begin
                r.byte_class = CLS_EXTRA;
                if (idx + 1 >= 32'(xlen_w)) leave_section(PH_EXTRA);
                else sec_idx = idx + 1;
            end
            PH_DATA: begin
                r.byte_class = CLS_DATA;
                if (idx >= plen_w - 32'd1) begin
                    r.data_last = 1'b1;
                    leave_section(PH_DATA);
                end else begin
                    sec_idx = idx + 1;
                end
            end
            PH_DESC: begin
                r.byte_class = CLS_DESC;
                // descriptor length is known once its lead word is in
                if (idx < 4) lead_w[8*idx[1:0] +: 8] = b;
                if (idx == 3) desc_len = (lead_w == DESC_SIG) ? DESC_LONG : DESC_SHORT;
                if (desc_len != 0 && idx + 1 >= 32'(desc_len)) leave_section(PH_DESC);
                else sec_idx = idx + 1;
            end
            default: begin
                r.byte_class = CLS_STOP;
                walk_phase   = PH_STOP;
            end
        endcase
        r.byte_out         = b;
        r.comp_method      = method_w;
        r.method_supported = (method_w == METHOD_STORE || method_w == METHOD_DEFLATE);
        r.packed_size      = plen_w;
        r.unpacked_size    = ulen_w;
        r.entry_number     = entry_cnt;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    // predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_results.push_back(walk_byte(s_byte_in));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result with none expected, expected none, actual %0h",
                             $time, m_byte_out);
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_class", 32'(want.byte_class), 32'(m_byte_class));
                    check_field("byte_out", 32'(want.byte_out), 32'(m_byte_out));
                    check_field("header_done", 32'(want.header_done), 32'(m_header_done));
                    check_field("name_last", 32'(want.name_last), 32'(m_name_last));
                    check_field("data_last", 32'(want.data_last), 32'(m_data_last));
                    check_field("comp_method", 32'(want.comp_method), 32'(m_comp_method));
                    check_field("method_supported", 32'(want.method_supported),
                                32'(m_method_supported));
                    check_field("packed_size", want.packed_size, m_packed_size);
                    check_field("unpacked_size", want.unpacked_size, m_unpacked_size);
                    check_field("entry_number", 32'(want.entry_number), 32'(m_entry_number));
                end
            end
        end
    end

    // result side: random stall bursts, started only while idle_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drive one byte and return at the edge where it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // one well-formed local entry with random filler content
    task automatic send_entry(input logic [15:0] flags, input logic [15:0] method,
                              input logic [31:0] plen, input logic [31:0] ulen,
                              input logic [15:0] nlen, input logic [15:0] xlen,
                              input bit desc_tagged);
        logic [7:0]  hdr [0:29];
        logic [31:0] lead;
        {hdr[3], hdr[2], hdr[1], hdr[0]}       = LOCAL_SIG;
        {hdr[5], hdr[4]}                       = 16'($urandom);
        {hdr[7], hdr[6]}                       = flags;
        {hdr[9], hdr[8]}                       = method;
        {hdr[13], hdr[12], hdr[11], hdr[10]}   = $urandom;
        {hdr[17], hdr[16], hdr[15], hdr[14]}   = $urandom;
        {hdr[21], hdr[20], hdr[19], hdr[18]}   = plen;
        {hdr[25], hdr[24], hdr[23], hdr[22]}   = ulen;
        {hdr[27], hdr[26]}                     = nlen;
        {hdr[29], hdr[28]}                     = xlen;
        for (int i = 0; i < 30; i++) send_byte(hdr[i]);
        repeat (nlen) send_byte(8'($urandom));
        repeat (xlen) send_byte(8'($urandom));
        repeat (plen) send_byte(8'($urandom));
        if (flags[DESC_FLAG_BIT]) begin
            // untagged lead word must not look like the descriptor signature
            if (desc_tagged) begin
                lead = DESC_SIG;
            end else begin
                lead = $urandom;
                if (lead == DESC_SIG) lead[0] = ~lead[0];
            end
            for (int i = 0; i < 4; i++) send_byte(lead[8*i +: 8]);
            repeat (desc_tagged ? 12 : 8) send_byte(8'($urandom));
        end
    endtask

    // header only, every section empty: entry closes on the last header byte
    task automatic test_empty_entry();
        send_entry(16'h0000, METHOD_STORE, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        send_entry(16'h0000, METHOD_DEFLATE, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0);
    endtask

    // one byte in each section plus a tagged descriptor
    task automatic test_minimal_sections();
        send_entry(16'h0008, METHOD_DEFLATE, 32'd1, 32'd1, 16'd1, 16'd1, 1'b1);
    endtask

    // all flag bits set, unsupported method, empty extra and data, short, then long descriptor
    task automatic test_short_descriptor();
        send_entry(16'hFFFF, 16'hFFFF, 32'd0, 32'd5, 16'd2, 16'd0, 1'b0);
        send_entry(16'h0008, METHOD_STORE, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
    endtask

    // name length with its upper byte in use, plus small extra and data sections
    task automatic test_large_sections();
        send_entry(16'h0000, METHOD_DEFLATE, 32'h0000_0020, 32'h8000_0001,
                   16'h0100, 16'h0002, 1'b0);
    endtask

    // random well-formed entries, mostly small
    task automatic test_random_entries(input int n_bytes);
        int          start;
        logic [15:0] method;
        logic [15:0] flags;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            case ($urandom_range(0, 3))
                0:       method = METHOD_STORE;
                1:       method = METHOD_DEFLATE;
                default: method = 16'($urandom);
            endcase
            flags = 16'($urandom);
            if ($urandom_range(0, 15) == 0) begin
                flags[DESC_FLAG_BIT] = 1'b0;
                send_entry(flags, method, 32'd0, $urandom, 16'd0, 16'd0, 1'b0);
            end else begin
                send_entry(flags, method, $urandom_range(0, 12), $urandom,
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
                           1'($urandom_range(0, 1)));
            end
        end
    endtask

    // one good entry, then a signature wrong only in its last byte, then noise on a stopped walk
    task automatic test_signature_stop();
        send_entry(16'h0000, METHOD_STORE, 32'd2, 32'd2, 16'd1, 16'd0, 1'b0);
        send_byte(LOCAL_SIG[7:0]);
        send_byte(LOCAL_SIG[15:8]);
        send_byte(LOCAL_SIG[23:16]);
        send_byte(LOCAL_SIG[31:24] ^ 8'h80);
        repeat (60) send_byte(8'($urandom));
        for (int i = 0; i < 4; i++) send_byte(LOCAL_SIG[8*i +: 8]);
        repeat (30) send_byte(8'($urandom));
    endtask

    initial begin
        clear_walker();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_entry();
        test_minimal_sections();
        test_short_descriptor();
        test_large_sections();
        test_random_entries(650);
        // closing stretch runs back to back on both sides
        idle_on <= 1'b0;
        test_random_entries(250);
        test_signature_stop();
        s_valid <= 1'b0;

        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/zlhw_pkg.sv
rtl/core/zlhw_core.sv
rtl/core/zip_local_header_walker.sv
rtl/core/zlhw_checker.sv
dv/zip_local_header_walker_tb.sv
